### hdl/rsmp_pkg.sv
package rsmp_pkg;

	localparam int unsigned CoordW = 32;
	localparam int unsigned DistW  = 32;
	localparam int unsigned IndexW = 10;
	localparam int unsigned CountW = 11;
	localparam int unsigned SpanW  = DistW + 1;
	localparam int unsigned ProdW  = CoordW + DistW;
	localparam int unsigned StepW  = 7;
	localparam int unsigned MulSteps = DistW;
	localparam int unsigned DivSteps = ProdW;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RD_A,
		ST_RD_B,
		ST_RD_C,
		ST_CALC,
		ST_LERP,
		ST_OUT
	} rsmp_state_t;

	typedef struct packed {
		logic [DistW-1:0] w0;
		logic [SpanW-1:0] span;
	} lerp_req_t;

endpackage

### hdl/polyline_arclength_resampler.sv
// Load requests are accepted back to back while no query is in work.
// A query first runs a linear scan of the distance memory over the active vertices,
// one entry per cycle. One that lands on a single vertex, is clamped or meets a zero
// span then outputs a vertex; one that interpolates runs 32 multiply and 64 divide
// steps of the shift-add/restoring unit. One query is in work at a time.
// Reset clears control and sets vertex_count to 1; vertex tables are not cleared.
module polyline_arclength_resampler #(
	parameter int unsigned MAX_VERTICES = 1024
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [rsmp_pkg::CountW-1:0] cfg_wdata,
	input  logic s_tvalid,
	output logic s_tready,
	// vertex_index, coord_x, coord_y, distance, zero pad
	input  logic [111:0] s_tdata,
	// cmd
	input  logic [0:0] s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// point_x, point_y
	output logic [63:0] m_tdata,
	// clamped
	output logic [0:0] m_tuser
);
	import rsmp_pkg::*;

	localparam int unsigned AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int unsigned CW = $clog2(MAX_VERTICES + 1);

	rsmp_state_t state_q, state_d;

	logic [CountW-1:0] vertex_count_q;
	logic [IndexW-1:0] in_index;
	logic [CoordW-1:0] in_x, in_y;
	logic [DistW-1:0] in_dist;
	logic accept, load_we;

	logic [CW-1:0] n_eff, n_q, iss_q;
	logic issuing;
	logic vld_s1;
	logic [AW-1:0] idx_s1;
	logic [DistW-1:0] t_q;
	logic have_lo_q, have_hi_q;
	logic [AW-1:0] lo_q, hi_q;
	logic single, clamp;
	logic [AW-1:0] raddr;
	logic [CoordW-1:0] rx, ry;
	logic [DistW-1:0] rd;
	logic [CoordW-1:0] ax_q, ay_q, bx_q, by_q;
	logic [DistW-1:0] ad_q, bd_q;
	logic [DistW-1:0] w0;
	logic [SpanW-1:0] span;
	lerp_req_t req;
	logic lerp_start, lerp_done_x, lerp_done_y;
	logic [CoordW-1:0] lx, ly;
	logic [CoordW-1:0] px_q, py_q;
	logic pc_q;
	logic out_load;

	assign in_index = s_tdata[9:0];
	assign in_x = s_tdata[41:10];
	assign in_y = s_tdata[73:42];
	assign in_dist = s_tdata[105:74];

	assign s_tready = (state_q == ST_IDLE);
	assign accept = s_tvalid && s_tready;
	assign load_we = accept && (s_tuser[0] == CMD_LOAD)
		&& ({22'd0, in_index} < MAX_VERTICES);

	always_comb begin
		if (vertex_count_q == '0) begin
			n_eff = CW'(1);
		end else if (32'(vertex_count_q) > MAX_VERTICES) begin
			n_eff = CW'(MAX_VERTICES);
		end else begin
			n_eff = CW'(vertex_count_q);
		end
	end

	assign issuing = (state_q == ST_SCAN) && (iss_q < n_q);
	assign single = !have_lo_q || !have_hi_q || (lo_q == hi_q);
	assign clamp = !(have_lo_q && have_hi_q);

	always_comb begin
		case (state_q)
			ST_RD_A: raddr = have_lo_q ? lo_q : hi_q;
			ST_RD_B: raddr = hi_q;
			default: raddr = iss_q[AW-1:0];
		endcase
	end

	rsmp_vmem #(.DEPTH(MAX_VERTICES), .AW(AW)) u_vmem (
		.clk(clk),
		.we(load_we),
		.waddr(AW'(in_index)),
		.wx(in_x),
		.wy(in_y),
		.wd(in_dist),
		.raddr(raddr),
		.rx(rx),
		.ry(ry),
		.rd(rd)
	);

	assign w0 = t_q - ad_q;
	assign span = {1'b0, w0} + {1'b0, bd_q - t_q};
	assign req = '{w0: w0, span: span};

	rsmp_lerp u_lerp_x (
		.clk(clk), .arst_n(arst_n), .start(lerp_start), .req(req),
		.c0(ax_q), .c1(bx_q), .done(lerp_done_x), .res(lx)
	);

	rsmp_lerp u_lerp_y (
		.clk(clk), .arst_n(arst_n), .start(lerp_start), .req(req),
		.c0(ay_q), .c1(by_q), .done(lerp_done_y), .res(ly)
	);

	always_comb begin
		state_d = state_q;
		lerp_start = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && s_tuser[0] == CMD_QUERY) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (!issuing && !vld_s1) begin
					state_d = ST_RD_A;
				end
			end
			ST_RD_A: state_d = ST_RD_B;
			ST_RD_B: state_d = single ? ST_OUT : ST_RD_C;
			ST_RD_C: state_d = ST_CALC;
			ST_CALC: begin
				if (span == '0) begin
					state_d = ST_OUT;
				end else begin
					lerp_start = 1'b1;
					state_d = ST_LERP;
				end
			end
			ST_LERP: begin
				if (lerp_done_x && lerp_done_y) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!m_tvalid || m_tready) begin
					out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= CountW'(1);
			vld_s1 <= 1'b0;
			iss_q <= '0;
			have_lo_q <= 1'b0;
			have_hi_q <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (cfg_we) begin
				vertex_count_q <= cfg_wdata;
			end
			vld_s1 <= issuing;
			if (accept) begin
				iss_q <= '0;
				have_lo_q <= 1'b0;
				have_hi_q <= 1'b0;
			end else begin
				if (issuing) begin
					iss_q <= iss_q + 1'b1;
				end
				if (vld_s1) begin
					if (rd <= t_q) begin
						have_lo_q <= 1'b1;
					end
					if (rd >= t_q) begin
						have_hi_q <= 1'b1;
					end
				end
			end
			if (out_load) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			t_q <= in_dist;
			n_q <= n_eff;
		end
		idx_s1 <= iss_q[AW-1:0];
		if (vld_s1) begin
			if (rd <= t_q) begin
				lo_q <= idx_s1;
			end
			// Only the first vertex at or above the target is kept.
			if (rd >= t_q && !have_hi_q) begin
				hi_q <= idx_s1;
			end
		end
		if (state_q == ST_RD_B) begin
			ax_q <= rx;
			ay_q <= ry;
			ad_q <= rd;
		end
		if (state_q == ST_RD_C) begin
			bx_q <= rx;
			by_q <= ry;
			bd_q <= rd;
		end
		if (state_q == ST_RD_B && single) begin
			px_q <= rx;
			py_q <= ry;
			pc_q <= clamp;
		end else if (state_q == ST_CALC && span == '0) begin
			px_q <= ax_q;
			py_q <= ay_q;
			pc_q <= 1'b0;
		end else if (state_q == ST_LERP && lerp_done_x) begin
			px_q <= lx;
			py_q <= ly;
			pc_q <= 1'b0;
		end
		if (out_load) begin
			m_tdata <= {py_q, px_q};
			m_tuser <= pc_q;
		end
	end

endmodule

### hdl/rsmp_vmem.sv
module rsmp_vmem #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned AW = 10
) (
	input  logic clk,
	input  logic we,
	input  logic [AW-1:0] waddr,
	input  logic [rsmp_pkg::CoordW-1:0] wx,
	input  logic [rsmp_pkg::CoordW-1:0] wy,
	input  logic [rsmp_pkg::DistW-1:0] wd,
	input  logic [AW-1:0] raddr,
	output logic [rsmp_pkg::CoordW-1:0] rx,
	output logic [rsmp_pkg::CoordW-1:0] ry,
	output logic [rsmp_pkg::DistW-1:0] rd
);
	import rsmp_pkg::*;

	logic [CoordW-1:0] x_mem [DEPTH];
	logic [CoordW-1:0] y_mem [DEPTH];
	logic [DistW-1:0]  d_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			x_mem[waddr] <= wx;
			y_mem[waddr] <= wy;
			d_mem[waddr] <= wd;
		end
		rx <= x_mem[raddr];
		ry <= y_mem[raddr];
		rd <= d_mem[raddr];
	end

endmodule

### hdl/rsmp_lerp.sv
module rsmp_lerp (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  rsmp_pkg::lerp_req_t req,
	input  logic [rsmp_pkg::CoordW-1:0] c0,
	input  logic [rsmp_pkg::CoordW-1:0] c1,
	output logic done,
	output logic [rsmp_pkg::CoordW-1:0] res
);
	import rsmp_pkg::*;

	logic busy_q;
	logic [StepW-1:0] step_q;
	logic neg_q;
	logic [CoordW-1:0] base_q;
	logic [ProdW-1:0] acc_q;
	logic [ProdW-1:0] mcand_q;
	logic [DistW-1:0] mplier_q;
	logic [SpanW-1:0] span_q;
	logic [SpanW-1:0] rem_q;
	logic [CoordW:0] diff;
	logic [CoordW-1:0] mag;
	logic [SpanW:0] rem_sh;
	logic [SpanW:0] rem_sub;
	logic qbit;

	assign diff = {c1[CoordW-1], c1} - {c0[CoordW-1], c0};
	assign mag = diff[CoordW] ? CoordW'(-diff) : diff[CoordW-1:0];

	// Restoring division step: the dividend shifts out of acc_q while the
	// quotient bits shift in behind it.
	assign rem_sh = {rem_q, acc_q[ProdW-1]};
	assign rem_sub = rem_sh - {1'b0, span_q};
	assign qbit = !rem_sub[SpanW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == StepW'(MulSteps + DivSteps - 1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= diff[CoordW];
			base_q <= c0;
			acc_q <= '0;
			mcand_q <= ProdW'(mag);
			mplier_q <= req.w0;
			span_q <= req.span;
			rem_q <= '0;
		end else if (busy_q) begin
			if (step_q < StepW'(MulSteps)) begin
				if (mplier_q[0]) begin
					acc_q <= acc_q + mcand_q;
				end
				mcand_q <= {mcand_q[ProdW-2:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[DistW-1:1]};
			end else begin
				rem_q <= qbit ? rem_sub[SpanW-1:0] : rem_sh[SpanW-1:0];
				acc_q <= {acc_q[ProdW-2:0], qbit};
			end
		end
	end

	assign res = neg_q ? base_q - acc_q[CoordW-1:0] : base_q + acc_q[CoordW-1:0];

endmodule

### tb/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import rsmp_pkg::*;

	localparam int unsigned NVERT = 1024;
	localparam int unsigned STALL_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CountW-1:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [111:0] s_tdata = '0;
	logic [0:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic [0:0] m_tuser;

	typedef struct packed {
		logic [CoordW-1:0] px;
		logic [CoordW-1:0] py;
		logic clamped;
	} point_t;

	logic [CoordW-1:0] tbl_x [NVERT];
	logic [CoordW-1:0] tbl_y [NVERT];
	logic [DistW-1:0] tbl_d [NVERT];
	int unsigned active_count = 1;
	point_t expected_points[$];
	int errors = 0;
	int points_seen = 0;
	int queries_sent = 0;
	int loads_sent = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int quiet_cycles = 0;

	polyline_arclength_resampler u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [CoordW-1:0] lerp(logic [CoordW-1:0] c0, logic [CoordW-1:0] c1,
			logic [63:0] w0, logic [63:0] span);
		longint signed a, b, d, r;
		logic [127:0] q;
		logic [63:0] mag;
		a = longint'(signed'(c0));
		b = longint'(signed'(c1));
		d = b - a;
		mag = (d < 0) ? -d : d;
		q = (128'(mag) * 128'(w0)) / 128'(span);
		r = (d < 0) ? a - longint'(q[63:0]) : a + longint'(q[63:0]);
		return r[31:0];
	endfunction

	function automatic point_t resample_at(logic [DistW-1:0] t);
		int unsigned n, lo, hi, pick;
		bit have_lo, have_hi;
		logic [63:0] w0, span;
		point_t p;
		n = active_count == 0 ? 1 : (active_count > NVERT ? NVERT : active_count);
		lo = 0; hi = 0; have_lo = 0; have_hi = 0;
		for (int j = 0; j < n; j++) begin
			if (tbl_d[j] <= t) begin
				lo = j;
				have_lo = 1;
			end
			if (tbl_d[j] >= t && !have_hi) begin
				hi = j;
				have_hi = 1;
			end
		end
		p.clamped = 1'b0;
		if (!have_lo || !have_hi || lo == hi) begin
			pick = have_lo ? lo : hi;
			p.px = tbl_x[pick];
			p.py = tbl_y[pick];
			p.clamped = (have_lo && have_hi) ? 1'b0 : 1'b1;
			return p;
		end
		w0 = 64'(t) - 64'(tbl_d[lo]);
		span = w0 + (64'(tbl_d[hi]) - 64'(t));
		if (span == 0) begin
			p.px = tbl_x[lo];
			p.py = tbl_y[lo];
			return p;
		end
		p.px = lerp(tbl_x[lo], tbl_x[hi], w0, span);
		p.py = lerp(tbl_y[lo], tbl_y[hi], w0, span);
		return p;
	endfunction

	// The valid line stays high after an accepted request unless the sender idles,
	// so back-to-back requests never drive it twice in one step.
	task automatic send_request(logic cmd, logic [IndexW-1:0] idx, logic [CoordW-1:0] x,
			logic [CoordW-1:0] y, logic [DistW-1:0] d);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {6'd0, d, y, x, idx};
		do @(posedge clk); while (!s_tready);
		if (cmd == CMD_LOAD) begin
			tbl_x[idx] = x;
			tbl_y[idx] = y;
			tbl_d[idx] = d;
			loads_sent++;
		end else begin
			expected_points.push_back(resample_at(d));
			queries_sent++;
		end
	endtask

	task automatic load_vertex(int unsigned i, logic [CoordW-1:0] x, logic [CoordW-1:0] y,
			logic [DistW-1:0] d);
		send_request(CMD_LOAD, i[IndexW-1:0], x, y, d);
	endtask

	task automatic query_at(logic [DistW-1:0] t);
		send_request(CMD_QUERY, '0, '0, '0, t);
	endtask

	// Wait for all results, then let the block finish any trailing work.
	task automatic drain;
		s_tvalid <= 1'b0;
		while (expected_points.size() != 0) @(posedge clk);
		repeat (NVERT + 120) @(posedge clk);
	endtask

	task automatic set_count(int unsigned n);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= n[CountW-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		active_count = n;
	endtask

	// Builds a non-decreasing polyline over slots 0..n-1 with random coordinates.
	task automatic load_polyline(int unsigned n, int unsigned max_step);
		logic [DistW-1:0] d;
		d = $urandom_range(1000);
		for (int unsigned i = 0; i < n; i++) begin
			load_vertex(i, $urandom, $urandom, d);
			if ($urandom_range(7) != 0) d = d + $urandom_range(max_step);
		end
	endtask

	function automatic logic [DistW-1:0] pick_target();
		int unsigned n, k;
		n = active_count == 0 ? 1 : (active_count > NVERT ? NVERT : active_count);
		k = $urandom_range(n - 1);
		case ($urandom_range(5))
			0: return $urandom;
			1: return tbl_d[k];
			2: return tbl_d[k] - 1;
			default: return tbl_d[k] + $urandom_range(40000);
		endcase
	endfunction

	always @(posedge clk) begin
		if (arst_n) m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		point_t exp_p;
		if (arst_n && m_tvalid && m_tready) begin
			points_seen++;
			if (expected_points.size() == 0) begin
				$display("%0t: unexpected point x=%h y=%h clamped=%b", $time,
					m_tdata[31:0], m_tdata[63:32], m_tuser);
				errors++;
			end else begin
				exp_p = expected_points.pop_front();
				if (m_tdata[31:0] !== exp_p.px || m_tdata[63:32] !== exp_p.py ||
						m_tuser[0] !== exp_p.clamped) begin
					$display("%0t: point mismatch expected x=%h y=%h c=%b actual x=%h y=%h c=%b",
						$time, exp_p.px, exp_p.py, exp_p.clamped,
						m_tdata[31:0], m_tdata[63:32], m_tuser);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: watchdog expired, %0d points outstanding", $time,
				expected_points.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic test_directed;
		// One active vertex: every query lands on it.
		load_vertex(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
		query_at(32'h0001_0000);
		query_at(32'h0000_0000);
		query_at(32'hFFFF_FFFF);
		set_count(4);
		load_vertex(1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0003_0000);
		load_vertex(2, 32'h0000_0010, 32'hFFFF_FFF0, 32'h0003_0000);
		load_vertex(3, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
		query_at(32'h0002_0000);
		query_at(32'h0003_0000);
		query_at(32'h0001_8000);
		query_at(32'hFFFF_FFFE);
		query_at(32'h0000_0000);
		// Out-of-order distances.
		load_vertex(2, 32'h1234_5678, 32'h8765_4321, 32'h0000_0100);
		query_at(32'h0000_0200);
		query_at(32'h0000_0100);
		load_vertex(1023, 32'hFFFF_FFFF, 32'h0, 32'h0);
		set_count(0);
		query_at(32'h0001_0000);
		query_at(32'h0);
	endtask

	task automatic test_random_phase(int unsigned n, int unsigned step, int items);
		set_count(n);
		load_polyline(n, step);
		for (int i = 0; i < items; i++) begin
			if ($urandom_range(9) == 0)
				load_vertex($urandom_range(n - 1), $urandom, $urandom, $urandom);
			else
				query_at(pick_target());
		end
	endtask

	task automatic test_long_table;
		set_count(48);
		load_polyline(48, 4000);
		repeat (8) query_at(pick_target());
		query_at(32'hFFFF_FFFF);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 33;
		recv_idle_pct = 46;
		test_directed();
		test_random_phase(2, 70000, 40);
		test_random_phase(9, 1 << 20, 60);
		send_idle_pct = 46;
		recv_idle_pct = 33;
		test_random_phase(16, 300, 60);
		test_random_phase(5, 32'h2000_0000, 50);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_phase(32, 100000, 80);
		test_long_table();
		drain();
		$display("Covered %0d loads and %0d queries (%0d points checked)",
			loads_sent, queries_sent, points_seen);
		$display("Vertex counts 0..48, clamped/zero-span/out-of-order cases, mixed stalls.");
		if (errors == 0 && expected_points.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule

### filelist.f
hdl/rsmp_pkg.sv
hdl/rsmp_vmem.sv
hdl/rsmp_lerp.sv
hdl/polyline_arclength_resampler.sv
tb/tb_top.sv
